// File: rtl/s20_pkg.sv
// Shared types, constants and helper functions of the Salsa20 keystream engine.
`default_nettype none

package s20_pkg;

	// 32-bit word, 16-word matrix, 8-word key
	typedef logic [31:0] word_t;
	typedef logic [15:0][31:0] matrix_t;
	typedef logic [7:0][31:0] key_t;

	localparam int ROUNDS_DEF = 20;
	localparam int LANE_CNT = 4;

	// tau (16-byte key) and sigma (32-byte key) constants
	localparam word_t CONST_W0 = 32'h61707865;
	localparam word_t TAU_W1 = 32'h3120646e;
	localparam word_t TAU_W2 = 32'h79622d36;
	localparam word_t SIGMA_W1 = 32'h3320646e;
	localparam word_t SIGMA_W2 = 32'h79622d32;
	localparam word_t CONST_W3 = 32'h6b206574;

	// rotation amounts of the four quarter-round steps
	localparam int ROT_A = 7;
	localparam int ROT_B = 9;
	localparam int ROT_C = 13;
	localparam int ROT_D = 18;

	typedef enum logic [1:0] {
		CMD_RESTART = 2'd0,
		CMD_DATA    = 2'd1,
		CMD_SEEK    = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_KEY_A   = 3'd0,
		REG_KEY_B   = 3'd1,
		REG_KEY_C   = 3'd2,
		REG_KEY_D   = 3'd3,
		REG_NONCE_A = 3'd4,
		REG_NONCE_B = 3'd5,
		REG_NONCE_C = 3'd6,
		REG_MODE    = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_HSTART,
		ST_HSAL,
		ST_LOAD,
		ST_BLOCK,
		ST_DATA,
		ST_EMIT
	} state_t;

	// control word from the sequencer to the round core
	typedef struct packed {
		logic start;
		logic feed;
	} core_ctrl_t;

	// word index of one role (a, b, c, d) of one quarter-round lane
	function automatic logic [3:0] qr_index(input logic row, input logic [1:0] lane,
			input logic [1:0] role);
		logic [3:0] idx;
		idx = 4'd0;
		case ({row, lane})
			3'b000: idx = 4'(role) * 4'd4;
			3'b001: begin
				case (role)
					2'd0: idx = 4'd5;
					2'd1: idx = 4'd9;
					2'd2: idx = 4'd13;
					default: idx = 4'd1;
				endcase
			end
			3'b010: begin
				case (role)
					2'd0: idx = 4'd10;
					2'd1: idx = 4'd14;
					2'd2: idx = 4'd2;
					default: idx = 4'd6;
				endcase
			end
			3'b011: begin
				case (role)
					2'd0: idx = 4'd15;
					2'd1: idx = 4'd3;
					2'd2: idx = 4'd7;
					default: idx = 4'd11;
				endcase
			end
			3'b100: idx = {2'b00, role};
			3'b101: begin
				case (role)
					2'd0: idx = 4'd5;
					2'd1: idx = 4'd6;
					2'd2: idx = 4'd7;
					default: idx = 4'd4;
				endcase
			end
			3'b110: begin
				case (role)
					2'd0: idx = 4'd10;
					2'd1: idx = 4'd11;
					2'd2: idx = 4'd8;
					default: idx = 4'd9;
				endcase
			end
			default: begin
				case (role)
					2'd0: idx = 4'd15;
					2'd1: idx = 4'd12;
					2'd2: idx = 4'd13;
					default: idx = 4'd14;
				endcase
			end
		endcase
		return idx;
	endfunction

	// lay out the input matrix; words 8 and 9 come from w89
	function automatic matrix_t build_matrix(input logic sigma, input key_t sub,
			input logic [1:0][31:0] nonce, input logic [63:0] w89);
		matrix_t m;
		m[0] = CONST_W0;
		m[5] = sigma ? SIGMA_W1 : TAU_W1;
		m[10] = sigma ? SIGMA_W2 : TAU_W2;
		m[15] = CONST_W3;
		for (int i = 0; i < 4; i++) begin
			m[1 + i] = sub[i];
			m[11 + i] = sub[4 + i];
		end
		m[6] = nonce[0];
		m[7] = nonce[1];
		m[8] = w89[31:0];
		m[9] = w89[63:32];
		return m;
	endfunction

endpackage

`default_nettype wire

// File: rtl/s20_qstep.sv
// One quarter-round lane: one add, rotate and xor step.
`default_nettype none

module s20_qstep (
	input  s20_pkg::word_t  p,
	input  s20_pkg::word_t  q,
	input  s20_pkg::word_t  t,
	input  logic [1:0]      step,
	output s20_pkg::word_t  y
);
	import s20_pkg::*;

	word_t sum;
	word_t rot;

	// add the two sources, rotate by the step's amount, fold into the target
	always_comb begin
		sum = p + q;
		case (step)
			2'd0: rot = {sum[31-ROT_A:0], sum[31:32-ROT_A]};
			2'd1: rot = {sum[31-ROT_B:0], sum[31:32-ROT_B]};
			2'd2: rot = {sum[31-ROT_C:0], sum[31:32-ROT_C]};
			default: rot = {sum[31-ROT_D:0], sum[31:32-ROT_D]};
		endcase
		y = t ^ rot;
	end

endmodule

`default_nettype wire

// File: rtl/s20_core.sv
// Iterative Salsa20 permutation: four quarter-round lanes and an optional feed-forward add.
`default_nettype none

module s20_core #(
	parameter int ROUNDS = s20_pkg::ROUNDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  s20_pkg::core_ctrl_t ctrl,
	input  s20_pkg::matrix_t    m_in,
	output logic                done,
	output s20_pkg::matrix_t    x_out
);
	import s20_pkg::*;

	localparam int STEPS = (ROUNDS / 2) * 8;
	localparam int CNT_W = $clog2(STEPS);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

	logic             busy_q;
	logic             fin_q;
	logic             done_q;
	logic             feed_q;
	logic [CNT_W-1:0] cnt_q;
	matrix_t          x_q;
	matrix_t          m_q;
	matrix_t          res_q;
	matrix_t          x_next;
	matrix_t          x_sum;
	logic [1:0]       step;
	logic             row;
	logic [3:0]       t_idx [LANE_CNT];
	word_t            lane_y [LANE_CNT];

	assign step = cnt_q[1:0];
	assign row = cnt_q[2];

	// four independent quarter-round lanes of the current half round
	for (genvar l = 0; l < LANE_CNT; l++) begin : g_lane
		logic [3:0] p_idx;
		logic [3:0] q_idx;
		assign p_idx = qr_index(row, 2'(l), step);
		assign q_idx = qr_index(row, 2'(l), step - 2'd1);
		assign t_idx[l] = qr_index(row, 2'(l), step + 2'd1);
		s20_qstep u_step (
			.p    (x_q[p_idx]),
			.q    (x_q[q_idx]),
			.t    (x_q[t_idx[l]]),
			.step (step),
			.y    (lane_y[l])
		);
	end

	// merge lane results into the matrix
	always_comb begin
		x_next = x_q;
		for (int l = 0; l < LANE_CNT; l++) begin
			x_next[t_idx[l]] = lane_y[l];
		end
	end

	// feed-forward add of the input matrix
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			x_sum[i] = x_q[i] + m_q[i];
		end
	end

	// sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	// working matrix and result
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			x_q <= m_in;
			m_q <= m_in;
			feed_q <= ctrl.feed;
		end else if (busy_q) begin
			x_q <= x_next;
		end
		if (fin_q) begin
			res_q <= feed_q ? x_sum : x_q;
		end
	end

	assign done = done_q;
	assign x_out = res_q;

endmodule

`default_nettype wire

// File: rtl/salsa20_stream_cipher.sv
// Top level of the Salsa20/20 and XSalsa20 keystream engine.
// Configuration: write key, nonce and mode through cfg_we/cfg_index/cfg_data while idle;
// they take effect at the next restart command.
// Input words (s_*): tuser carries the command (restart, data, seek); tdata carries
// data bytes, byte count and seek offset. Every input word yields one output word (m_*)
// with the XORed bytes and their count (zero for restart, seek and unknown commands).
// Timing: the round core runs four quarter-round lanes, one add-rotate-xor step per cycle.
// A restart costs one block, two with the extended nonce (the subkey derivation runs
// the same core). A seek costs one block. A data word that stays inside the current
// block passes through the data and emit states into the output register; one that
// reaches a 64-byte boundary adds a block.
// One word is in work at a time; s_tready is high while the engine is idle.
// The output register holds a result until m_tready; the next word is taken meanwhile,
// and its result waits for the register to empty.
// Reset clears configuration, key schedule, counter and position; a restart must
// precede the first data or seek word.
`default_nettype none

module salsa20_stream_cipher #(
	parameter int ROUNDS = s20_pkg::ROUNDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,   // data_in[63:0], byte_count[67:64], seek_offset[131:68]
	input  logic [1:0]   s_tuser,   // cmd[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata    // data_out[63:0], valid_count[67:64]
);
	import s20_pkg::*;

	// configuration registers
	logic [63:0] key_a_q, key_b_q, key_c_q, key_d_q;
	logic [63:0] nonce_a_q, nonce_b_q, nonce_c_q;
	logic [1:0]  mode_q;

	// key schedule and stream position
	key_t             sub_q;
	logic [1:0][31:0] nonce_q;
	logic             sigma_q;
	logic [63:0]      ctr_q;
	logic [6:0]       pos_q;
	matrix_t          ks_q;

	// item in work
	state_t      state_q, state_d;
	cmd_t        cmd_q;
	logic [63:0] data_q;
	logic [3:0]  n_q;
	logic [3:0]  done_q;
	logic [63:0] res_q;

	// output register
	logic        m_valid_q;
	logic [63:0] m_data_q;
	logic [3:0]  m_cnt_q;

	// decoded controls
	logic        accept;
	logic        out_free;
	logic        out_load;
	core_ctrl_t  core_ctrl;
	matrix_t     core_m;
	logic        core_done;
	matrix_t     core_x;
	cmd_t        in_cmd;
	logic [3:0]  in_cnt;
	logic [63:0] in_seek;
	key_t        key_all;

	// byte lanes of one data step
	logic [63:0][7:0] ks_bytes;
	logic [6:0]       avail;
	logic [3:0]       rem;
	logic [3:0]       take;
	logic [6:0]       pos_next;
	logic [3:0]       done_next;
	logic [63:0]      res_next;

	assign in_cmd = cmd_t'(s_tuser);
	assign in_cnt = s_tdata[67:64];
	assign in_seek = s_tdata[131:68];
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign key_all = {key_d_q, key_c_q, key_b_q, key_a_q};
	assign ks_bytes = ks_q;

	s20_core #(.ROUNDS(ROUNDS)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (core_ctrl),
		.m_in   (core_m),
		.done   (core_done),
		.x_out  (core_x)
	);

	// byte lanes: XOR what fits before the block end
	always_comb begin
		logic [7:0] off;
		avail = 7'd64 - pos_q;
		rem = n_q - done_q;
		take = ({3'b000, rem} > avail) ? avail[3:0] : rem;
		pos_next = pos_q + {3'b000, take};
		done_next = done_q + take;
		res_next = res_q;
		for (int i = 0; i < 8; i++) begin
			off = {1'b0, pos_q} + 8'(i) - {4'b0000, done_q};
			if (4'(i) >= done_q && 4'(i) < n_q && off < 8'd64) begin
				res_next[8*i +: 8] = data_q[8*i +: 8] ^ ks_bytes[off[5:0]];
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (in_cmd)
						CMD_RESTART: state_d = ST_PREP;
						CMD_DATA: state_d = ST_DATA;
						CMD_SEEK: state_d = ST_LOAD;
						default: state_d = ST_EMIT;
					endcase
				end
			end
			ST_PREP: state_d = mode_q[1] ? ST_HSTART : ST_LOAD;
			ST_HSTART: state_d = ST_HSAL;
			ST_HSAL: if (core_done) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_BLOCK;
			ST_BLOCK: if (core_done) state_d = (cmd_q == CMD_DATA) ? ST_DATA : ST_EMIT;
			ST_DATA: begin
				if (pos_next == 7'd64) state_d = ST_LOAD;
				else if (done_next == n_q) state_d = ST_EMIT;
			end
			ST_EMIT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = 1'b0;
		out_load = 1'b0;
		core_ctrl = '0;
		core_m = build_matrix(sigma_q, sub_q, nonce_q, ctr_q);
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_HSTART: begin
				core_ctrl.start = 1'b1;
				core_m = build_matrix(sigma_q, sub_q, nonce_q, nonce_b_q);
			end
			ST_LOAD: begin
				core_ctrl.start = 1'b1;
				core_ctrl.feed = 1'b1;
			end
			ST_EMIT: out_load = out_free;
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_a_q <= '0;
			key_b_q <= '0;
			key_c_q <= '0;
			key_d_q <= '0;
			nonce_a_q <= '0;
			nonce_b_q <= '0;
			nonce_c_q <= '0;
			mode_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_KEY_A: key_a_q <= cfg_data;
				REG_KEY_B: key_b_q <= cfg_data;
				REG_KEY_C: key_c_q <= cfg_data;
				REG_KEY_D: key_d_q <= cfg_data;
				REG_NONCE_A: nonce_a_q <= cfg_data;
				REG_NONCE_B: nonce_b_q <= cfg_data;
				REG_NONCE_C: nonce_c_q <= cfg_data;
				REG_MODE: mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// key schedule, counter and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= '0;
			nonce_q <= '0;
			sigma_q <= 1'b0;
			ctr_q <= '0;
			pos_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && in_cmd == CMD_SEEK) begin
						ctr_q <= {6'd0, in_seek[63:6]};
						pos_q <= {1'b0, in_seek[5:0]};
					end
				end
				ST_PREP: begin
					for (int i = 0; i < 8; i++) begin
						sub_q[i] <= mode_q[0] ? key_all[i] : key_all[i % 4];
					end
					nonce_q <= nonce_a_q;
					sigma_q <= mode_q[0];
					ctr_q <= '0;
					pos_q <= '0;
				end
				ST_HSAL: begin
					if (core_done) begin
						sub_q <= {core_x[9], core_x[8], core_x[7], core_x[6],
							core_x[15], core_x[10], core_x[5], core_x[0]};
						nonce_q <= nonce_c_q;
					end
				end
				ST_BLOCK: begin
					if (core_done) begin
						ctr_q <= ctr_q + 64'd1;
						if (cmd_q == CMD_DATA) pos_q <= '0;
					end
				end
				ST_DATA: pos_q <= pos_next;
				default: ;
			endcase
		end
	end

	// keystream block
	always_ff @(posedge clk) begin
		if (state_q == ST_BLOCK && core_done) begin
			ks_q <= core_x;
		end
	end

	// item registers: latch on accept, advance through data steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= CMD_RESTART;
			n_q <= '0;
			done_q <= '0;
		end else if (accept) begin
			cmd_q <= in_cmd;
			n_q <= (in_cnt > 4'd8) ? 4'd8 : in_cnt;
			done_q <= '0;
		end else if (state_q == ST_DATA) begin
			done_q <= done_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= s_tdata[63:0];
			res_q <= '0;
		end else if (state_q == ST_DATA) begin
			res_q <= res_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= res_q;
			m_cnt_q <= (cmd_q == CMD_DATA) ? n_q : 4'd0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {4'd0, m_cnt_q, m_data_q};

	// checks
	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		core_done |-> (state_q == ST_HSAL || state_q == ST_BLOCK))
		else $error("core finished outside a block or subkey run");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 7'd64)
		else $error("byte position beyond block");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q <= n_q) && (n_q <= 4'd8))
		else $error("processed byte count beyond item");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second word taken while one is in work");

endmodule

`default_nettype wire

// File: tb/sv/tb_salsa20_stream_cipher.sv
// Self-checking testbench of the Salsa20/XSalsa20 keystream engine with its own keystream model.
`default_nettype none

module tb_salsa20_stream_cipher;
	import s20_pkg::*;

	typedef struct packed {
		cmd_t        cmd;
		logic [63:0] data;
		logic [3:0]  count;
		logic [63:0] offset;
	} cipher_word_t;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  count;
	} cipher_result_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [63:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;   // data_in[63:0], byte_count[67:64], seek_offset[131:68]
	logic [1:0]   s_tuser;   // cmd[1:0]
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;   // data_out[63:0], valid_count[67:64]

	salsa20_stream_cipher dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// model copy of registers and stream state
	logic [63:0]  reg_val [8];
	logic [31:0]  mdl_input [16];
	logic [31:0]  mdl_keystream [16];
	logic [63:0]  mdl_counter;
	int unsigned  mdl_pos;

	cipher_word_t   pending_words [$];
	cipher_result_t expected_results [$];
	cipher_word_t   cur_word;
	int  mismatches;
	int  send_idle_pct, recv_idle_pct;
	bit  sending;

	function automatic logic [31:0] rotl(logic [31:0] v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void quarter(ref logic [31:0] x [16], input int a, b, c, d);
		x[b] ^= rotl(x[a] + x[d], 7);
		x[c] ^= rotl(x[b] + x[a], 9);
		x[d] ^= rotl(x[c] + x[b], 13);
		x[a] ^= rotl(x[d] + x[c], 18);
	endfunction

	function automatic void double_rounds(ref logic [31:0] x [16]);
		for (int i = 0; i < ROUNDS_DEF / 2; i++) begin
			quarter(x, 0, 4, 8, 12);
			quarter(x, 5, 9, 13, 1);
			quarter(x, 10, 14, 2, 6);
			quarter(x, 15, 3, 7, 11);
			quarter(x, 0, 1, 2, 3);
			quarter(x, 5, 6, 7, 4);
			quarter(x, 10, 11, 8, 9);
			quarter(x, 15, 12, 13, 14);
		end
	endfunction

	// make the block for the current counter, then advance it
	function automatic void next_block();
		logic [31:0] x [16];
		mdl_input[8] = mdl_counter[31:0];
		mdl_input[9] = mdl_counter[63:32];
		x = mdl_input;
		double_rounds(x);
		for (int i = 0; i < 16; i++)
			mdl_keystream[i] = x[i] + mdl_input[i];
		mdl_counter++;
	endfunction

	function automatic void rebuild_state();
		logic [31:0] k [8], sub [8], non [2], x [16], c1, c2;
		logic sig;
		sig = reg_val[REG_MODE][0];
		c1 = sig ? 32'h3320646e : 32'h3120646e;
		c2 = sig ? 32'h79622d32 : 32'h79622d36;
		for (int i = 0; i < 4; i++) begin
			k[2 * i] = reg_val[i][31:0];
			k[2 * i + 1] = reg_val[i][63:32];
		end
		for (int i = 0; i < 8; i++)
			sub[i] = sig ? k[i] : k[i & 3];
		non[0] = reg_val[REG_NONCE_A][31:0];
		non[1] = reg_val[REG_NONCE_A][63:32];
		if (reg_val[REG_MODE][1]) begin
			// derive the extended-nonce subkey
			x[0] = 32'h61707865; x[5] = c1; x[10] = c2; x[15] = 32'h6b206574;
			for (int i = 0; i < 4; i++) begin
				x[1 + i] = sub[i];
				x[11 + i] = sub[4 + i];
			end
			x[6] = non[0]; x[7] = non[1];
			x[8] = reg_val[REG_NONCE_B][31:0]; x[9] = reg_val[REG_NONCE_B][63:32];
			double_rounds(x);
			sub[0] = x[0]; sub[1] = x[5]; sub[2] = x[10]; sub[3] = x[15];
			sub[4] = x[6]; sub[5] = x[7]; sub[6] = x[8]; sub[7] = x[9];
			non[0] = reg_val[REG_NONCE_C][31:0];
			non[1] = reg_val[REG_NONCE_C][63:32];
		end
		mdl_input[0] = 32'h61707865; mdl_input[5] = c1;
		mdl_input[10] = c2; mdl_input[15] = 32'h6b206574;
		for (int i = 0; i < 4; i++) begin
			mdl_input[1 + i] = sub[i];
			mdl_input[11 + i] = sub[4 + i];
		end
		mdl_input[6] = non[0];
		mdl_input[7] = non[1];
		mdl_counter = '0;
		next_block();
		mdl_pos = 0;
	endfunction

	function automatic cipher_result_t encrypt_word(cipher_word_t w);
		cipher_result_t r;
		int n;
		logic [7:0] ks;
		r = '0;
		case (w.cmd)
			CMD_RESTART: rebuild_state();
			CMD_DATA: begin
				n = (w.count > 8) ? 8 : int'(w.count);
				for (int i = 0; i < n; i++) begin
					ks = 8'(mdl_keystream[mdl_pos >> 2] >> ((mdl_pos & 3) * 8));
					r.data[i * 8 +: 8] = w.data[i * 8 +: 8] ^ ks;
					mdl_pos++;
					if (mdl_pos >= 64) begin
						next_block();
						mdl_pos = 0;
					end
				end
				r.count = 4'(n);
			end
			CMD_SEEK: begin
				mdl_counter = w.offset >> 6;
				next_block();
				mdl_pos = 32'(w.offset[5:0]);
			end
			default: ;
		endcase
		return r;
	endfunction

	// clock and reset
	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver: present words from the pending queue; the model runs on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(encrypt_word(cur_word));
			end
			if (!s_tvalid || s_tready) begin
				if (pending_words.size() > 0 && sending
						&& $urandom_range(99) >= send_idle_pct) begin
					cur_word = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= cur_word.cmd;
					s_tdata <= {4'd0, cur_word.offset, cur_word.count, cur_word.data};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word data=%h count=%0d", m_tdata[63:0],
							m_tdata[67:64]);
				end else begin
					cipher_result_t e;
					e = expected_results.pop_front();
					if (m_tdata[63:0] !== e.data || m_tdata[67:64] !== e.count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp data=%h count=%0d got data=%h count=%0d",
								e.data, e.count, m_tdata[63:0], m_tdata[67:64]);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic cipher_word_t data_word(logic [63:0] d, logic [3:0] n);
		cipher_word_t w;
		w.cmd = CMD_DATA; w.data = d; w.count = n; w.offset = {$urandom, $urandom};
		return w;
	endfunction

	function automatic cipher_word_t ctrl_word(cmd_t c, logic [63:0] off);
		cipher_word_t w;
		w.cmd = c; w.data = {$urandom, $urandom}; w.count = 4'($urandom); w.offset = off;
		return w;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		reg_val[idx] = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for the block to drain, then a margin longer than the longest block latency
	task automatic drain();
		while (pending_words.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic run_phase(int mode, int items, int s_pct, int r_pct);
		int k;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		write_reg(REG_KEY_A, rnd64());
		write_reg(REG_KEY_B, rnd64());
		write_reg(REG_KEY_C, rnd64());
		write_reg(REG_KEY_D, rnd64());
		write_reg(REG_NONCE_A, ($urandom_range(3) == 0) ? 64'd0 : rnd64());
		write_reg(REG_NONCE_B, rnd64());
		write_reg(REG_NONCE_C, rnd64());
		write_reg(REG_MODE, 64'(mode));
		pending_words.push_back(ctrl_word(CMD_RESTART, rnd64()));
		k = 0;
		while (k < items) begin
			case ($urandom_range(19))
				0: pending_words.push_back(ctrl_word(CMD_RESTART, rnd64()));
				1: pending_words.push_back(ctrl_word(CMD_SEEK, rnd64()));
				2: pending_words.push_back(ctrl_word(CMD_SEEK, 64'($urandom_range(1000))));
				3: pending_words.push_back(ctrl_word(CMD_NONE, rnd64()));
				4: pending_words.push_back(data_word(rnd64(), 4'($urandom_range(15))));
				default: pending_words.push_back(data_word(rnd64(),
					4'($urandom_range(8, 1))));
			endcase
			k++;
		end
		drain();
	endtask

	initial begin
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		sending = 1'b1;
		send_idle_pct = 29;
		recv_idle_pct = 68;
		for (int i = 0; i < 8; i++) reg_val[i] = '0;
		for (int i = 0; i < 16; i++) begin
			mdl_input[i] = '0;
			mdl_keystream[i] = '0;
		end
		mdl_counter = '0;
		mdl_pos = 0;
		@(posedge arst_n);
		@(posedge clk);

		// directed: all-zero key, extremes of fields, every command, seeks near wraps
		write_reg(REG_MODE, 64'd0);
		pending_words.push_back(ctrl_word(CMD_RESTART, '0));
		pending_words.push_back(data_word('1, 4'd8));
		pending_words.push_back(data_word('0, 4'd1));
		pending_words.push_back(data_word(rnd64(), 4'd0));
		pending_words.push_back(data_word(rnd64(), 4'd15));
		pending_words.push_back(data_word(rnd64(), 4'd9));
		pending_words.push_back(ctrl_word(CMD_NONE, '1));
		pending_words.push_back(ctrl_word(CMD_SEEK, 64'd60));
		pending_words.push_back(data_word(rnd64(), 4'd8));
		pending_words.push_back(ctrl_word(CMD_SEEK, '1));
		pending_words.push_back(data_word(rnd64(), 4'd8));
		pending_words.push_back(data_word(rnd64(), 4'd8));
		pending_words.push_back(ctrl_word(CMD_SEEK, 64'h0000_0001_0000_0000 * 64 - 3));
		pending_words.push_back(data_word('1, 4'd8));
		pending_words.push_back(ctrl_word(CMD_SEEK, '0));
		pending_words.push_back(data_word(rnd64(), 4'd7));
		drain();

		write_reg(REG_KEY_A, '1);
		write_reg(REG_KEY_B, '1);
		write_reg(REG_KEY_C, '1);
		write_reg(REG_KEY_D, '1);
		write_reg(REG_NONCE_A, '1);
		write_reg(REG_NONCE_B, '1);
		write_reg(REG_NONCE_C, '1);
		write_reg(REG_MODE, 64'd3);
		pending_words.push_back(ctrl_word(CMD_RESTART, '0));
		pending_words.push_back(data_word('1, 4'd8));
		pending_words.push_back(ctrl_word(CMD_SEEK, 64'd127));
		pending_words.push_back(data_word(rnd64(), 4'd8));
		drain();

		// random phases through all modes and idling profiles
		run_phase(0, 160, 29, 68);
		run_phase(1, 160, 29, 68);
		run_phase(2, 110, 29, 68);
		run_phase(3, 110, 68, 29);
		run_phase(0, 110, 68, 29);
		run_phase(1, 110, 68, 29);
		run_phase(2, 200, 0, 0);
		run_phase(3, 300, 0, 0);

		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// give up after a generous fixed time
	initial begin
		#8000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
